FILE: design/efl_pkg.sv
// shared types and constants for the free-list allocator
`timescale 1ns / 1ps
package efl_pkg;
  localparam int HEAP_BYTES  = 65536;
  localparam int ALIGN_BYTES = 8;
  localparam int HDR_BYTES   = 8;
  localparam int MIN_SPLIT   = 24;
  localparam int MIN_PAYLOAD = 16;
  localparam int NWORDS      = HEAP_BYTES / HDR_BYTES;
  localparam int AW          = $clog2(NWORDS);
  localparam int WORD_W      = 18;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NULL   = 2'd1;
  localparam logic [1:0] ST_NOSPC  = 2'd2;
  localparam logic [1:0] ST_DBLFRE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        done;
    logic [15:0] offset;
    logic [1:0]  status;
  } efl_res_t;
endpackage

FILE: design/explicit_free_list_allocator_top.sv
// top level: channels, heap size register and result register
`timescale 1ns / 1ps
// First-fit heap allocator over an 8192-word header memory. Each item walks the
// header chain, reading one header per block visited through the single ram port.
// After reset or a heap_bytes write the block lays out the initial free block.
module explicit_free_list_allocator_top import efl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [16:0] in_request_bytes,
  input  logic [15:0] in_payload_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_offset,
  output logic [1:0]  out_status,
  output logic [16:0] out_used_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_heap_bytes
);
  logic        idle;
  efl_res_t    res;
  logic [16:0] used;
  logic [16:0] heap_lim_r;
  logic        busy_r;
  logic        out_valid_r;
  logic        cfg_fire, in_fire;

  // a pending register write takes priority over an input beat
  assign in_ready  = idle && !busy_r && !out_valid_r && !cfg_valid;
  assign cfg_ready = idle && !busy_r && !out_valid_r;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready && !cfg_fire;
  assign out_valid = out_valid_r;

  efl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_valid && in_ready), .load(cfg_fire),
    .op(in_operation), .req(in_request_bytes), .ptr(in_payload_offset),
    .heap_lim(heap_lim_r), .idle(idle), .res(res), .used(used)
  );

  // heap size clamp and alignment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_lim_r <= 17'(HEAP_BYTES);
    end else if (cfg_fire) begin
      heap_lim_r <= (cfg_heap_bytes > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES)
                  : (cfg_heap_bytes & ~17'(ALIGN_BYTES - 1));
    end
  end

  // item in flight and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (res.done) begin
        busy_r <= 1'b0;
      end
      if (res.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res.done) begin
      out_result_offset <= res.offset;
      out_status        <= res.status;
      out_used_bytes    <= used;
    end
  end

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input accepted with result pending");
  a_used_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_bytes >= 17'(HDR_BYTES)) else $error("used below header");
  a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> busy_r) else $error("result without item");
endmodule

FILE: design/efl_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module efl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/efl_ctrl.sv
// sequencer that walks the header chain through one shared address adder
`timescale 1ns / 1ps
module efl_ctrl import efl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        load,
  input  logic        op,
  input  logic [16:0] req,
  input  logic [15:0] ptr,
  input  logic [16:0] heap_lim,
  output logic        idle,
  output efl_res_t    res,
  output logic [16:0] used
);
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_ASPL  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FHDR  = 4'd7;
  localparam logic [3:0] S_FNXT  = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [17:0] o_r, o_nxt;
  logic [16:0] need_r, need_nxt;
  logic [16:0] sz_r, sz_nxt;
  logic [15:0] ptr_r, ptr_nxt;
  logic [16:0] used_r, used_nxt;
  logic        hvalid_r, hvalid_nxt;
  efl_res_t    res_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [16:0] hsz;
  logic [17:0] step;
  logic [17:0] rnd;
  logic [17:0] need_c;
  logic [18:0] space;

  efl_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign hsz  = {rdata[16:3], 3'b000};
  // shared adder: next header offset
  assign step = o_r + 18'(HDR_BYTES) + {1'b0, (state_r == S_FHDR || state_r == S_ASPL)
                                               ? sz_r : hsz};
  assign rnd    = ({1'b0, req} + 18'(ALIGN_BYTES - 1)) & ~18'(ALIGN_BYTES - 1);
  assign need_c = (rnd < 18'(MIN_PAYLOAD)) ? 18'(MIN_PAYLOAD) : rnd;
  assign space  = {2'b00, used_r} + 19'(HDR_BYTES) + {1'b0, need_c};

  assign idle = (state_r == S_IDLE);
  assign used = used_r;

  always_comb begin
    state_nxt  = state_r;
    o_nxt      = o_r;
    need_nxt   = need_r;
    sz_nxt     = sz_r;
    ptr_nxt    = ptr_r;
    used_nxt   = used_r;
    hvalid_nxt = hvalid_r;
    res_nxt    = '0;
    we         = 1'b0;
    addr       = o_r[AW+2:3];
    wdata      = '0;
    case (state_r)
      // lay out one free block if the heap holds at least MIN_SPLIT bytes
      S_INIT: begin
        hvalid_nxt = (heap_lim >= 17'(MIN_SPLIT));
        used_nxt   = 17'(HDR_BYTES);
        addr       = '0;
        we         = (heap_lim >= 17'(MIN_SPLIT));
        wdata      = {1'b0, heap_lim - 17'(HDR_BYTES)} | 18'd1;
        state_nxt  = S_IDLE;
      end
      // take an item, or go back to laying out the heap on a register write
      S_IDLE: begin
        o_nxt    = '0;
        need_nxt = need_c[16:0];
        ptr_nxt  = ptr;
        if (load) begin
          state_nxt = S_INIT;
        end else if (start) begin
          res_nxt.done = 1'b1;
          if (op == OP_ALLOC) begin
            if (req == '0) begin
              res_nxt.status = ST_NULL;
            end else if (!hvalid_r || space > {2'b00, heap_lim}) begin
              res_nxt.status = ST_NOSPC;
            end else begin
              res_nxt.done = 1'b0;
              state_nxt    = S_ARD;
            end
          end else begin
            if (ptr == '0 || !hvalid_r) begin
              res_nxt.status = ST_NULL;
            end else begin
              res_nxt.done = 1'b0;
              state_nxt    = S_FRD;
            end
          end
        end
      end
      // allocate: read next header, or stop at the end of the heap
      S_ARD: begin
        if (o_r >= {1'b0, heap_lim}) begin
          res_nxt.done   = 1'b1;
          res_nxt.status = ST_NOSPC;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      // allocate: test fit
      S_ACHK: begin
        sz_nxt = hsz;
        if (rdata[0] && hsz == need_r) begin
          we             = 1'b1;
          wdata          = {1'b0, need_r};
          used_nxt       = used_r + need_r;
          res_nxt.done   = 1'b1;
          res_nxt.status = ST_DONE;
          res_nxt.offset = 16'(o_r + 18'(HDR_BYTES));
          state_nxt      = S_IDLE;
        end else if (rdata[0] && ({1'b0, need_r} + 18'(MIN_SPLIT)) <= {1'b0, hsz}) begin
          we        = 1'b1;
          wdata     = {1'b0, need_r};
          sz_nxt    = need_r;
          need_nxt  = hsz - need_r - 17'(HDR_BYTES);
          state_nxt = S_ASPL;
        end else begin
          o_nxt     = step;
          state_nxt = S_ARD;
        end
      end
      // allocate: write tail header
      S_ASPL: begin
        addr           = step[AW+2:3];
        we             = 1'b1;
        wdata          = {1'b0, need_r} | 18'd1;
        used_nxt       = used_r + sz_r + 17'(HDR_BYTES);
        res_nxt.done   = 1'b1;
        res_nxt.status = ST_DONE;
        res_nxt.offset = 16'(o_r + 18'(HDR_BYTES));
        state_nxt      = S_IDLE;
      end
      // free: walk to the block
      S_FRD: begin
        if (o_r < {1'b0, heap_lim} && (o_r + 18'(HDR_BYTES)) < {2'b00, ptr_r}) begin
          state_nxt = S_FCHK;
        end else if (o_r >= {1'b0, heap_lim} ||
                     (o_r + 18'(HDR_BYTES)) != {2'b00, ptr_r}) begin
          res_nxt.done   = 1'b1;
          res_nxt.status = ST_NULL;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_FHDR;
        end
      end
      S_FCHK: begin
        o_nxt     = step;
        state_nxt = S_FRD;
      end
      // free: own header is in rdata
      S_FHDR: begin
        if (rdata[0]) begin
          res_nxt.done   = 1'b1;
          res_nxt.status = ST_DBLFRE;
          state_nxt      = S_IDLE;
        end else begin
          sz_nxt = hsz;
          if ((o_r + 18'(HDR_BYTES) + {1'b0, hsz}) < {1'b0, heap_lim}) begin
            addr      = 13'((o_r + 18'(HDR_BYTES) + {1'b0, hsz}) >> 3);
            state_nxt = S_FNXT;
          end else begin
            we             = 1'b1;
            wdata          = {1'b0, hsz} | 18'd1;
            used_nxt       = used_r - hsz;
            res_nxt.done   = 1'b1;
            res_nxt.status = ST_DONE;
            state_nxt      = S_IDLE;
          end
        end
      end
      // free: mark the block free, merged with the following block if that is free
      S_FNXT: begin
        we             = 1'b1;
        res_nxt.done   = 1'b1;
        res_nxt.status = ST_DONE;
        state_nxt      = S_IDLE;
        if (rdata[0]) begin
          wdata    = {1'b0, sz_r + 17'(HDR_BYTES) + hsz} | 18'd1;
          used_nxt = used_r - sz_r - 17'(HDR_BYTES);
        end else begin
          wdata    = {1'b0, sz_r} | 18'd1;
          used_nxt = used_r - sz_r;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      used_r   <= 17'(HDR_BYTES);
      hvalid_r <= 1'b0;
      res      <= '0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      hvalid_r <= hvalid_nxt;
      res      <= res_nxt;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    o_r    <= o_nxt;
    need_r <= need_nxt;
    sz_r   <= sz_nxt;
    ptr_r  <= ptr_nxt;
  end
endmodule

FILE: tb/explicit_free_list_allocator_top_tb.sv
// testbench for the free-list allocator: table-driven and random items checked against a heap model
`timescale 1ns / 1ps
module explicit_free_list_allocator_top_tb import efl_pkg::*;;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE      = 40;
  localparam int LIVE_CAP    = 100;

  // dut ports; the inputs are all known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_ALLOC;
  logic [16:0] in_request_bytes = '0;
  logic [15:0] in_payload_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_result_offset;
  logic [1:0]  out_status;
  logic [16:0] out_used_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_heap_bytes = '0;

  explicit_free_list_allocator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_request_bytes(in_request_bytes), .in_payload_offset(in_payload_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_offset(out_result_offset),
    .out_status(out_status), .out_used_bytes(out_used_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_heap_bytes(cfg_heap_bytes)
  );

  typedef struct {
    logic [15:0] offset;
    logic [1:0]  status;
    logic [16:0] used;
  } heap_answer_t;

  typedef struct {
    logic        op;
    logic [16:0] req;
    logic [15:0] off;
    bit          typed;
    heap_answer_t ans;
  } heap_row_t;

  // heap model state
  bit [17:0]   hdr_words [0:NWORDS-1];
  int unsigned model_used;
  int unsigned model_size;
  bit          model_valid;

  heap_answer_t answer_q[$];
  int unsigned  live_offsets[$];
  int unsigned  freed_offsets[$];

  int errors = 0;
  int items = 0;
  int results = 0;
  int n_alloc_ok = 0, n_free_ok = 0, n_nospace = 0, n_double = 0, n_null = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int cycles = 0;

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending", cycles, answer_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned hdr_rd(int unsigned off);
    return (off / 8 < NWORDS) ? int'(hdr_words[off / 8]) : 0;
  endfunction

  function automatic void hdr_wr(int unsigned off, int unsigned v);
    if (off / 8 < NWORDS) hdr_words[off / 8] = v[17:0];
  endfunction

  function automatic void heap_lay_out(int unsigned hb);
    int unsigned s;
    s = (hb > HEAP_BYTES) ? HEAP_BYTES : hb;
    s = s & ~32'd7;
    model_size = s;
    foreach (hdr_words[i]) hdr_words[i] = '0;
    model_used = HDR_BYTES;
    model_valid = (s >= MIN_SPLIT);
    if (model_valid) hdr_wr(0, (s - HDR_BYTES) | 1);
  endfunction

  function automatic logic [1:0] heap_alloc(int unsigned req, output int unsigned res);
    int unsigned need, o, h, sz;
    res = 0;
    if (req == 0) return ST_NULL;
    need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    if (need < MIN_PAYLOAD) need = MIN_PAYLOAD;
    if (!model_valid || model_used + HDR_BYTES + need > model_size) return ST_NOSPC;
    o = 0;
    while (o < model_size) begin
      h = hdr_rd(o);
      sz = h & ~32'd7;
      if (h[0]) begin
        // exact fit takes the block whole
        if (sz == need) begin
          hdr_wr(o, need);
          model_used += need;
          res = o + HDR_BYTES;
          return ST_DONE;
        end
        // big enough to split off a free tail
        if (need + MIN_SPLIT <= sz) begin
          hdr_wr(o, need);
          hdr_wr(o + HDR_BYTES + need, (sz - HDR_BYTES - need) | 1);
          model_used += need + HDR_BYTES;
          res = o + HDR_BYTES;
          return ST_DONE;
        end
      end
      o += HDR_BYTES + sz;
    end
    return ST_NOSPC;
  endfunction

  function automatic logic [1:0] heap_free(int unsigned p);
    int unsigned o, h, sz, nxt, nh;
    if (p == 0 || !model_valid) return ST_NULL;
    o = 0;
    while (o < model_size && o + HDR_BYTES < p) o += HDR_BYTES + (hdr_rd(o) & ~32'd7);
    if (o >= model_size || o + HDR_BYTES != p) return ST_NULL;
    h = hdr_rd(o);
    if (h[0]) return ST_DBLFRE;
    sz = h & ~32'd7;
    nxt = o + HDR_BYTES + sz;
    nh = hdr_rd(nxt);
    // merge forward only
    if (nxt < model_size && nh[0]) begin
      hdr_wr(o, (sz + HDR_BYTES + (nh & ~32'd7)) | 1);
      hdr_wr(nxt, 0);
      model_used -= HDR_BYTES + sz;
    end else begin
      hdr_wr(o, sz | 1);
      model_used -= sz;
    end
    return ST_DONE;
  endfunction

  // apply one accepted beat to the model and keep the live list in step
  function automatic heap_answer_t heap_apply(logic op, logic [16:0] req, logic [15:0] off);
    heap_answer_t a;
    int unsigned r;
    int idx[$];
    r = 0;
    if (op == OP_FREE) a.status = heap_free(off);
    else a.status = heap_alloc(req, r);
    a.offset = r[15:0];
    a.used = model_used[16:0];
    if (a.status == ST_DONE && op == OP_ALLOC) begin
      live_offsets.push_back(r);
      n_alloc_ok++;
    end else if (a.status == ST_DONE) begin
      idx = live_offsets.find_first_index(x) with (x == off);
      if (idx.size() > 0) live_offsets.delete(idx[0]);
      freed_offsets.push_back(off);
      if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
      n_free_ok++;
    end
    case (a.status)
      ST_NOSPC:  n_nospace++;
      ST_DBLFRE: n_double++;
      ST_NULL:   n_null++;
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // send one beat, holding valid until accepted
  task automatic send_item(logic op, logic [16:0] req, logic [15:0] off, bit typed,
                           heap_answer_t typed_ans);
    heap_answer_t a;
    int gap;
    gap = 0;
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_bytes <= req;
    in_payload_offset <= off;
    do @(posedge clk); while (!in_ready);
    a = heap_apply(op, req, off);
    answer_q.push_back(typed ? typed_ans : a);
    items++;
  endtask

  // drain, settle, then write the heap size register
  task automatic write_heap_bytes(logic [16:0] v);
    in_valid <= 1'b0;
    while (answer_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_heap_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    heap_lay_out(v);
    live_offsets.delete();
    freed_offsets.delete();
  endtask

  // one random beat, mostly well-formed traffic on live blocks
  task automatic send_random();
    heap_answer_t none;
    int unsigned pick, req, off;
    bit do_free;
    none = '{default: '0};
    do_free = (live_offsets.size() > LIVE_CAP) || ($urandom_range(99) < 45);
    if (!do_free) begin
      pick = $urandom_range(99);
      if (pick < 2) req = 0;
      else if (pick < 5) req = $urandom_range(131071);
      else if (pick < 15) req = $urandom_range(1, 4096);
      else req = $urandom_range(1, 256);
      send_item(OP_ALLOC, req[16:0], 16'($urandom), 1'b0, none);
    end else begin
      pick = $urandom_range(99);
      if (pick < 75 && live_offsets.size() > 0)
        off = live_offsets[$urandom_range(live_offsets.size() - 1)];
      else if (pick < 85 && freed_offsets.size() > 0)
        off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
      else if (pick < 95) off = $urandom_range(65535);
      else off = 0;
      send_item(OP_FREE, 17'($urandom), off[15:0], 1'b0, none);
    end
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
    end
  end

  // compare each result beat with the oldest answer
  always @(posedge clk) begin
    heap_answer_t w;
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (answer_q.size() == 0) begin
        report_mismatch("result beat with nothing pending, status", out_status, 0);
      end else begin
        w = answer_q.pop_front();
        if (out_result_offset !== w.offset) report_mismatch("offset", out_result_offset, w.offset);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_used_bytes !== w.used) report_mismatch("used_bytes", out_used_bytes, w.used);
      end
    end
  end

  heap_row_t dir_rows[$];

  function automatic heap_row_t mk(logic op, int unsigned req, int unsigned off, bit typed,
                                   int unsigned eo = 0, logic [1:0] es = ST_DONE,
                                   int unsigned eu = 0);
    heap_row_t r;
    r.op = op; r.req = req[16:0]; r.off = off[15:0]; r.typed = typed;
    r.ans.offset = eo[15:0]; r.ans.status = es; r.ans.used = eu[16:0];
    return r;
  endfunction

  // main sequence
  initial begin
    int unsigned heaps[$];
    heap_lay_out(HEAP_BYTES);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // directed rows on the reset heap
    dir_rows.push_back(mk(OP_ALLOC, 0, 0, 1, 0, ST_NULL, 8));
    dir_rows.push_back(mk(OP_FREE, 0, 0, 1, 0, ST_NULL, 8));
    dir_rows.push_back(mk(OP_ALLOC, 1, 0, 1, 8, ST_DONE, 32));
    dir_rows.push_back(mk(OP_ALLOC, 65536, 0, 1, 0, ST_NOSPC, 32));
    dir_rows.push_back(mk(OP_ALLOC, 131071, 0, 1, 0, ST_NOSPC, 32));
    dir_rows.push_back(mk(OP_FREE, 0, 8, 1, 0, ST_DONE, 8));
    dir_rows.push_back(mk(OP_FREE, 0, 8, 1, 0, ST_DBLFRE, 8));
    dir_rows.push_back(mk(OP_FREE, 0, 12, 1, 0, ST_NULL, 8));
    dir_rows.push_back(mk(OP_ALLOC, 24, 0, 1, 8, ST_DONE, 40));
    dir_rows.push_back(mk(OP_ALLOC, 17, 0, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 8, 0));
    dir_rows.push_back(mk(OP_ALLOC, 24, 0, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 65535, 0));
    dir_rows.push_back(mk(OP_ALLOC, 65400, 0, 0));
    dir_rows.push_back(mk(OP_ALLOC, 65472, 0, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 40, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 40, 0));
    dir_rows.push_back(mk(OP_ALLOC, 65535, 0, 0));
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].req, dir_rows[i].off, dir_rows[i].typed,
                dir_rows[i].ans);

    // full heap, no idling
    write_heap_bytes(17'd65536);
    repeat (300) send_random();

    // mid heap, sender idles
    in_idle_pct = 48;
    write_heap_bytes(17'd4096);
    repeat (250) send_random();

    // oversized register value, receiver stalls and holds off once
    in_idle_pct = 0;
    out_stall_pct = 48;
    write_heap_bytes(17'h1FFFF);
    repeat (60) send_random();
    hold_req = 1'b1;
    repeat (190) send_random();

    // tiny heaps near the usable limit and one near full size, both sides idle
    in_idle_pct = 20;
    out_stall_pct = 20;
    heaps = '{200, 0, 23, 24, 31, 65535};
    foreach (heaps[i]) begin
      write_heap_bytes(heaps[i][16:0]);
      repeat (heaps[i] == 65535 ? 150 : 40) send_random();
    end

    in_valid <= 1'b0;
    while (answer_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("%0d items, %0d result beats: %0d allocs placed, %0d frees done", items, results,
             n_alloc_ok, n_free_ok);
    $display("%0d out of space, %0d double frees, %0d null or bad, %0d mismatches", n_nospace,
             n_double, n_null, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/efl_pkg.sv
design/efl_ram.sv
design/efl_ctrl.sv
design/explicit_free_list_allocator_top.sv
tb/explicit_free_list_allocator_top_tb.sv
